// File: hdl/fsvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsvt_pkg
// Shared types and constants of the frame slot validity tracker.
// ----------------------------------------------------------------------------
package fsvt_pkg;

   localparam int MAX_SLOTS = 64;
   localparam int SLOT_AW   = $clog2(MAX_SLOTS);
   localparam int CNT_W     = 7;
   localparam int ID_W      = 32;
   localparam int IDX_W     = 16;

   typedef enum logic [1:0] {
      CMD_WRITE      = 2'd0,
      CMD_ANALYSE    = 2'd1,
      CMD_INVALIDATE = 2'd2,
      CMD_QUERY      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN_MAX,
      ST_SCAN_MARK,
      ST_REPORT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic max_pass;
      logic mark_pass;
      logic restart;
      logic set_current;
      logic rsp_valid;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic pass_done;
   } stat_type;

endpackage

// File: hdl/fsvt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsvt_ctrl
// Sequencer: takes an item, runs the two slot walks of an analyse, reports.
// ----------------------------------------------------------------------------
module fsvt_ctrl
   import fsvt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] command,
   input  stat_type   stat,
   output ctl_type    ctl,
   output logic       busy
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (cmd_type'(command) == CMD_ANALYSE) ? ST_SCAN_MAX : ST_REPORT;
            end
         end
         ST_SCAN_MAX: begin
            if (stat.pass_done) begin
               state_in = ST_SCAN_MARK;
            end
         end
         ST_SCAN_MARK: begin
            if (stat.pass_done) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy       = 1'b0;
            ctl.accept = start;
         end
         ST_SCAN_MAX: begin
            ctl.max_pass = 1'b1;
            ctl.restart  = stat.pass_done;
         end
         ST_SCAN_MARK: begin
            ctl.mark_pass   = 1'b1;
            ctl.set_current = stat.pass_done;
         end
         ST_REPORT: begin
            ctl.rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// File: hdl/fsvt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsvt_datapath
// Slot memory, per-slot written and valid bits, analysis registers.
// ----------------------------------------------------------------------------
module fsvt_datapath
   import fsvt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  ctl_type          ctl,
   output stat_type         stat,
   input  logic [1:0]       command,
   input  logic [IDX_W-1:0] slot_index,
   input  logic [ID_W-1:0]  sample_frame_id,
   input  logic             sample_sync,
   input  logic             csr_write_en,
   input  logic [CNT_W-1:0] csr_write_data,
   output logic             status,
   output logic             slot_is_valid,
   output logic             frame_complete,
   output logic [CNT_W-1:0] valid_count,
   output logic [CNT_W-1:0] frame_size,
   output logic [ID_W-1:0]  frame_number
);

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);

   // slot word: sync flag above the frame id
   logic [ID_W:0]          mem [MAX_SLOTS];

   logic [MAX_SLOTS-1:0]   mark_ff, mark_in;
   logic [MAX_SLOTS-1:0]   vbits_ff, vbits_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       size_ff, size_in;
   logic                   current_ff, current_in;
   logic [ID_W-1:0]        newest_ff, newest_in;
   logic [CNT_W-1:0]       used_ff, used_in;
   logic [CNT_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [SLOT_AW-1:0]     rd_idx_ff;
   logic [ID_W:0]          rd_data_ff;
   logic                   rd_mark_ff;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   status_ff, status_in;

   logic                   req_in_range;
   logic                   wr_ok;
   logic                   clear_all;
   logic                   analyse_go;
   logic                   issue;
   logic [ID_W-1:0]        rd_id;
   logic                   rd_sync;
   logic                   hit;
   logic                   idx_in_range;

   assign req_in_range = slot_index < IDX_W'(used_ff);
   assign wr_ok        = ctl.accept && (cmd_type'(command) == CMD_WRITE) && req_in_range;
   assign clear_all    = csr_write_en ||
                         (ctl.accept && (cmd_type'(command) == CMD_INVALIDATE));
   assign analyse_go   = ctl.accept && (cmd_type'(command) == CMD_ANALYSE);
   assign issue        = (ctl.max_pass || ctl.mark_pass) && (rd_ptr_ff < used_ff);

   // never-written slots read as zero
   assign rd_id   = rd_mark_ff ? rd_data_ff[ID_W-1:0] : '0;
   assign rd_sync = rd_mark_ff & rd_data_ff[ID_W];
   assign hit     = ctl.mark_pass && rd_vld_ff && (newest_ff != '0) && (rd_id == newest_ff);

   assign stat.pass_done = (rd_ptr_ff == used_ff) && !rd_vld_ff;

   always_comb begin
      mark_in    = mark_ff;
      vbits_in   = vbits_ff;
      count_in   = count_ff;
      size_in    = size_ff;
      current_in = current_ff;
      newest_in  = newest_ff;
      used_in    = used_ff;
      rd_ptr_in  = rd_ptr_ff;
      rd_vld_in  = issue;
      idx_in     = idx_ff;
      status_in  = status_ff;

      if (clear_all) begin
         mark_in    = '0;
         vbits_in   = '0;
         count_in   = '0;
         size_in    = '0;
         current_in = 1'b0;
      end
      if (csr_write_en) begin
         used_in = (csr_write_data > MAX_CNT) ? MAX_CNT : csr_write_data;
      end
      if (ctl.accept) begin
         idx_in    = slot_index;
         status_in = (cmd_type'(command) == CMD_WRITE) && !req_in_range;
      end
      if (wr_ok) begin
         mark_in[slot_index[SLOT_AW-1:0]] = 1'b1;
         current_in = 1'b0;
      end
      if (analyse_go) begin
         newest_in  = '0;
         count_in   = '0;
         size_in    = '0;
         vbits_in   = '0;
         current_in = 1'b0;
         rd_ptr_in  = '0;
      end
      if (issue) begin
         rd_ptr_in = rd_ptr_ff + CNT_W'(1);
      end
      if (ctl.restart) begin
         rd_ptr_in = '0;
         rd_vld_in = 1'b0;
      end
      if (ctl.max_pass && rd_vld_ff && (rd_id > newest_ff)) begin
         newest_in = rd_id;
      end
      if (hit) begin
         vbits_in[rd_idx_ff] = 1'b1;
         count_in = count_ff + CNT_W'(1);
         size_in  = {1'b0, rd_idx_ff} + (rd_sync ? CNT_W'(1) : CNT_W'(2));
      end
      if (ctl.set_current) begin
         current_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff    <= '0;
         vbits_ff   <= '0;
         count_ff   <= '0;
         size_ff    <= '0;
         current_ff <= 1'b0;
         newest_ff  <= '0;
         used_ff    <= '0;
         rd_ptr_ff  <= '0;
         rd_vld_ff  <= 1'b0;
         status_ff  <= 1'b0;
      end else begin
         mark_ff    <= mark_in;
         vbits_ff   <= vbits_in;
         count_ff   <= count_in;
         size_ff    <= size_in;
         current_ff <= current_in;
         newest_ff  <= newest_in;
         used_ff    <= used_in;
         rd_ptr_ff  <= rd_ptr_in;
         rd_vld_ff  <= rd_vld_in;
         status_ff  <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[slot_index[SLOT_AW-1:0]] <= {sample_sync, sample_frame_id};
      end
      rd_data_ff <= mem[rd_ptr_ff[SLOT_AW-1:0]];
      rd_mark_ff <= mark_ff[rd_ptr_ff[SLOT_AW-1:0]];
      rd_idx_ff  <= rd_ptr_ff[SLOT_AW-1:0];
   end

   assign idx_in_range   = idx_ff < IDX_W'(used_ff);
   assign status         = status_ff;
   assign slot_is_valid  = current_ff && idx_in_range && vbits_ff[idx_ff[SLOT_AW-1:0]];
   assign frame_complete = (used_ff != '0) && current_ff && (size_ff == count_ff);
   assign valid_count    = current_ff ? count_ff : '0;
   assign frame_size     = current_ff ? size_ff : '0;
   assign frame_number   = newest_ff;

endmodule

// File: hdl/frame_slot_validity_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_slot_validity_tracker
// Tracks frame id and sync flag per sample slot and reports frame validity.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its one result shows
// for a single cycle with rsp_strobe and cannot be held off by the receiver.
// Write, invalidate and query go from accept to the report state and then back
// to idle. Analyse walks the slot memory twice, once for the largest frame id
// and once to mark and count the matching slots, at one read per cycle on the
// memory's single read port. With no slots in use, neither walk reads a slot.
// Writing the slot count clears all slot state in that same cycle.
// ----------------------------------------------------------------------------
module frame_slot_validity_tracker
   import fsvt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_command,
   input  logic [IDX_W-1:0] req_slot_index,
   input  logic [ID_W-1:0]  req_sample_frame_id,
   input  logic             req_sample_sync,
   input  logic             csr_write_en,
   input  logic [CNT_W-1:0] csr_write_data,
   output logic             rsp_strobe,
   output logic             rsp_status,
   output logic             rsp_slot_is_valid,
   output logic             rsp_frame_complete,
   output logic [CNT_W-1:0] rsp_valid_count,
   output logic [CNT_W-1:0] rsp_frame_size,
   output logic [ID_W-1:0]  rsp_frame_number
);

   ctl_type  ctl;
   stat_type stat;

   fsvt_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_command),
      .stat    (stat),
      .ctl     (ctl),
      .busy    (busy)
   );

   fsvt_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .stat            (stat),
      .command         (req_command),
      .slot_index      (req_slot_index),
      .sample_frame_id (req_sample_frame_id),
      .sample_sync     (req_sample_sync),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .status          (rsp_status),
      .slot_is_valid   (rsp_slot_is_valid),
      .frame_complete  (rsp_frame_complete),
      .valid_count     (rsp_valid_count),
      .frame_size      (rsp_frame_size),
      .frame_number    (rsp_frame_number)
   );

   assign rsp_strobe = ctl.rsp_valid;

endmodule

// File: tb/sv/tb_frame_slot_validity_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_slot_validity_tracker
// Self-checking bench: a slot table model predicts every response.
// ----------------------------------------------------------------------------
// Commands go in over the start/busy handshake. Each response is checked
// field by field against a model that tracks the slot table, the last
// analysis and the slot count. A short directed run covers the corner cases.
// Random phases follow, each under its own slot count and idle rate.
// Most random traffic fills whole frames and then analyses them.
// ----------------------------------------------------------------------------
module tb_frame_slot_validity_tracker;
   import fsvt_pkg::*;

   localparam int LIMIT_CYCLES = 400000;

   typedef struct packed {
      logic             status;
      logic             slot_is_valid;
      logic             frame_complete;
      logic [CNT_W-1:0] valid_count;
      logic [CNT_W-1:0] frame_size;
      logic [ID_W-1:0]  frame_number;
   } slot_report_t;

   class slot_table_model;
      logic [ID_W-1:0]  slot_id    [MAX_SLOTS];
      logic             slot_sync  [MAX_SLOTS];
      logic             slot_valid [MAX_SLOTS];
      int unsigned      valid_total;
      int unsigned      size_guess;
      bit               current;
      logic [ID_W-1:0]  newest_id;
      logic [CNT_W-1:0] slot_count;
      slot_report_t     pending_reports[$];
      int unsigned      errors;

      function new();
         clear_table();
         newest_id  = '0;
         slot_count = '0;
         errors     = 0;
      endfunction

      function void clear_table();
         for (int i = 0; i < MAX_SLOTS; i++) begin
            slot_id[i]    = '0;
            slot_sync[i]  = 1'b0;
            slot_valid[i] = 1'b0;
         end
         valid_total = 0;
         size_guess  = 0;
         current     = 1'b0;
      endfunction

      function int unsigned slots_used();
         return (slot_count > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count);
      endfunction

      function void set_slot_count(logic [CNT_W-1:0] value);
         slot_count = value;
         clear_table();
      endfunction

      function int unsigned pending();
         return pending_reports.size();
      endfunction

      function void log_failure(string msg);
         errors++;
         if (errors <= 10) $display("%s", msg);
      endfunction

      function void apply_item(logic [1:0] raw_cmd, logic [IDX_W-1:0] idx,
                               logic [ID_W-1:0] fid, logic sync);
         int unsigned     n;
         logic [ID_W-1:0] best;
         slot_report_t    rep;
         n   = slots_used();
         rep = '0;
         case (cmd_type'(raw_cmd))
            CMD_WRITE: begin
               if (idx < n) begin
                  slot_id[idx[SLOT_AW-1:0]]   = fid;
                  slot_sync[idx[SLOT_AW-1:0]] = sync;
                  current                     = 1'b0;
               end else begin
                  rep.status = 1'b1;
               end
            end
            CMD_ANALYSE: begin
               best = '0;
               for (int i = 0; i < n; i++)
                  if (slot_id[i] > best) best = slot_id[i];
               newest_id   = best;
               valid_total = 0;
               size_guess  = 0;
               for (int i = 0; i < n; i++) begin
                  if (best != 0 && slot_id[i] == best) begin
                     slot_valid[i] = 1'b1;
                     valid_total++;
                     size_guess = slot_sync[i] ? i + 1 : i + 2;
                  end else begin
                     slot_valid[i] = 1'b0;
                  end
               end
               current = 1'b1;
            end
            CMD_INVALIDATE: begin
               clear_table();
            end
            default: begin
            end
         endcase
         rep.slot_is_valid  = current && idx < n && slot_valid[idx[SLOT_AW-1:0]];
         rep.frame_complete = n != 0 && current && size_guess == valid_total;
         rep.valid_count    = current ? valid_total[CNT_W-1:0] : '0;
         rep.frame_size     = current ? size_guess[CNT_W-1:0] : '0;
         rep.frame_number   = newest_id;
         pending_reports.push_back(rep);
      endfunction

      function void check_report(slot_report_t got);
         slot_report_t want;
         bit           bad;
         if (pending_reports.size() == 0) begin
            log_failure($sformatf("unexpected response %p", got));
            return;
         end
         want = pending_reports.pop_front();
         bad  = (got.status !== want.status)
             || (got.slot_is_valid !== want.slot_is_valid)
             || (got.frame_complete !== want.frame_complete)
             || (got.valid_count !== want.valid_count)
             || (got.frame_size !== want.frame_size)
             || (got.frame_number !== want.frame_number);
         if (bad)
            log_failure($sformatf("response differs: expected %p got %p", want, got));
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   logic [1:0]       req_command;
   logic [IDX_W-1:0] req_slot_index;
   logic [ID_W-1:0]  req_sample_frame_id;
   logic             req_sample_sync;
   logic             csr_write_en;
   logic [CNT_W-1:0] csr_write_data;
   logic             rsp_strobe;
   logic             rsp_status;
   logic             rsp_slot_is_valid;
   logic             rsp_frame_complete;
   logic [CNT_W-1:0] rsp_valid_count;
   logic [CNT_W-1:0] rsp_frame_size;
   logic [ID_W-1:0]  rsp_frame_number;

   slot_table_model table_model = new();
   int unsigned     idle_pct = 0;
   int unsigned     cycle_count = 0;

   always #4 clock = ~clock;

   frame_slot_validity_tracker u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_slot_index      (req_slot_index),
      .req_sample_frame_id (req_sample_frame_id),
      .req_sample_sync     (req_sample_sync),
      .csr_write_en        (csr_write_en),
      .csr_write_data      (csr_write_data),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_slot_is_valid   (rsp_slot_is_valid),
      .rsp_frame_complete  (rsp_frame_complete),
      .rsp_valid_count     (rsp_valid_count),
      .rsp_frame_size      (rsp_frame_size),
      .rsp_frame_number    (rsp_frame_number)
   );

   // responses are checked before the item taken at the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            table_model.check_report({rsp_status, rsp_slot_is_valid, rsp_frame_complete,
                                      rsp_valid_count, rsp_frame_size, rsp_frame_number});
         if (start && !busy)
            table_model.apply_item(req_command, req_slot_index, req_sample_frame_id,
                                   req_sample_sync);
         if (csr_write_en)
            table_model.set_slot_count(csr_write_data);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("frame_slot_validity_tracker: mismatch");
         $finish;
      end
   end

   task automatic send_item(cmd_type cmd, logic [IDX_W-1:0] idx, logic [ID_W-1:0] fid,
                            logic sync);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start               <= 1'b1;
      req_command         <= cmd;
      req_slot_index      <= idx;
      req_sample_frame_id <= fid;
      req_sample_sync     <= sync;
      do @(posedge clock); while (busy);
   endtask

   // only with nothing in flight
   task automatic configure(logic [CNT_W-1:0] value);
      start <= 1'b0;
      @(posedge clock);
      while (table_model.pending() != 0 || busy) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   initial begin
      int unsigned     phase_cfg   [7];
      int unsigned     phase_idle  [7];
      int unsigned     phase_items [7];
      int unsigned     n;
      int unsigned     k;
      int unsigned     sent;
      int unsigned     r;
      logic [ID_W-1:0] fid;
      logic [IDX_W-1:0] idx;
      cmd_type         cmd;

      phase_cfg   = '{64, 1, 127, 0, 0, 0, 64};
      phase_idle  = '{0, 66, 20, 66, 0, 20, 66};
      phase_items = '{120, 60, 100, 100, 30, 90, 100};
      phase_cfg[3] = $urandom_range(2, 63);
      phase_cfg[5] = $urandom_range(2, 63);

      reset               <= 1'b1;
      start               <= 1'b0;
      req_command         <= CMD_QUERY;
      req_slot_index      <= '0;
      req_sample_frame_id <= '0;
      req_sample_sync     <= 1'b0;
      csr_write_en        <= 1'b0;
      csr_write_data      <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // no slots in use after reset
      send_item(CMD_WRITE, 16'd0, 32'd7, 1'b1);
      send_item(CMD_ANALYSE, 16'd0, 32'd0, 1'b0);
      send_item(CMD_QUERY, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);

      configure(7'd4);
      send_item(CMD_WRITE, 16'd0, 32'd5, 1'b0);
      send_item(CMD_WRITE, 16'd2, 32'd5, 1'b1);
      send_item(CMD_WRITE, 16'd1, 32'd3, 1'b0);
      send_item(CMD_ANALYSE, 16'd0, 32'd0, 1'b0);
      for (int i = 0; i < 4; i++) send_item(CMD_QUERY, IDX_W'(i), 32'd0, 1'b0);
      send_item(CMD_QUERY, 16'hFFFF, 32'd0, 1'b0);
      // out of range write keeps the analysis
      send_item(CMD_WRITE, 16'd4, 32'hFFFF_FFFF, 1'b1);
      send_item(CMD_WRITE, 16'd3, 32'hFFFF_FFFF, 1'b1);
      send_item(CMD_QUERY, 16'd2, 32'd0, 1'b0);
      send_item(CMD_ANALYSE, 16'd3, 32'd0, 1'b0);
      send_item(CMD_WRITE, 16'd3, 32'd5, 1'b1);
      send_item(CMD_WRITE, 16'd1, 32'd5, 1'b0);
      send_item(CMD_ANALYSE, 16'd1, 32'd0, 1'b0);
      send_item(CMD_QUERY, 16'd1, 32'd0, 1'b0);
      send_item(CMD_INVALIDATE, 16'd1, 32'd0, 1'b0);
      send_item(CMD_QUERY, 16'd1, 32'd0, 1'b0);

      for (int p = 0; p < 7; p++) begin
         configure(CNT_W'(phase_cfg[p]));
         idle_pct = phase_idle[p];
         n    = (phase_cfg[p] > MAX_SLOTS) ? MAX_SLOTS : phase_cfg[p];
         sent = 0;
         while (sent < phase_items[p]) begin
            if (n != 0 && sent + n + 3 <= phase_items[p] && $urandom_range(2) != 0) begin
               // fill one frame from slot 0, then analyse it
               k   = $urandom_range(1, n);
               fid = $urandom | 32'h8000_0000;
               if ($urandom_range(1) != 0) begin
                  send_item(CMD_INVALIDATE, IDX_W'($urandom), ID_W'($urandom),
                            1'($urandom_range(1)));
                  sent++;
               end
               for (int i = 0; i < k; i++)
                  send_item(CMD_WRITE, IDX_W'(i), fid,
                            (i == k - 1) && ($urandom_range(3) != 0));
               send_item(CMD_ANALYSE, IDX_W'($urandom_range(n - 1)), ID_W'($urandom),
                         1'($urandom_range(1)));
               send_item(CMD_QUERY, IDX_W'($urandom_range(n)), ID_W'($urandom),
                         1'($urandom_range(1)));
               sent += k + 2;
            end else begin
               r = $urandom_range(99);
               if (r < 50)      cmd = CMD_WRITE;
               else if (r < 65) cmd = CMD_ANALYSE;
               else if (r < 92) cmd = CMD_QUERY;
               else             cmd = CMD_INVALIDATE;
               if (n == 0 || $urandom_range(9) == 0) idx = IDX_W'($urandom);
               else                                  idx = IDX_W'($urandom_range(n - 1));
               r = $urandom_range(99);
               if (r < 45)      fid = ID_W'($urandom_range(1, 3));
               else if (r < 55) fid = '0;
               else if (r < 65) fid = 32'hFFFF_FFFF;
               else             fid = ID_W'($urandom);
               send_item(cmd, idx, fid, 1'($urandom_range(1)));
               sent++;
            end
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (table_model.pending() != 0) @(posedge clock);
      repeat (2 * MAX_SLOTS + 8) @(posedge clock);
      if (table_model.errors == 0 && table_model.pending() == 0)
         $display("frame_slot_validity_tracker: match");
      else
         $display("frame_slot_validity_tracker: mismatch");
      $finish;
   end

endmodule

// File: frame_slot_validity_tracker.f
hdl/fsvt_pkg.sv
hdl/fsvt_ctrl.sv
hdl/fsvt_datapath.sv
hdl/frame_slot_validity_tracker.sv
tb/sv/tb_frame_slot_validity_tracker.sv
